/* src/sparse_triple_compactor_defines.svh */
// Assertion macros used by the compactor design file.
`ifndef SPARSE_TRIPLE_COMPACTOR_DEFINES_SVH
`define SPARSE_TRIPLE_COMPACTOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define STC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/stc_pkg.sv */
`timescale 1ns / 1ps
package stc_pkg;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_COMPACT = 2'd1,
      OP_READ    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BAD_READ = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;

   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 80;
   localparam int TOL_BITS      = 31;

endpackage

/* src/stc_ram.sv */
`timescale 1ns / 1ps
module stc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sparse_triple_compactor.sv */
`timescale 1ns / 1ps
// Insert and clear are accepted from S_IDLE and the result is valid in the cycle after; back to
// back they can be accepted every cycle while rsp_tready is high. A read passes through S_RDW
// because of the registered memory read port, so reads are not accepted back to back.
// A compact of n entries stalls the input for ceil(log2 n) merge-sort passes, then a merge
// sweep; the sort uses one comparator.
// Reset is synchronous and active high: it empties the store and zeroes the tolerance.
`include "sparse_triple_compactor_defines.svh"
module sparse_triple_compactor #(
   parameter int CAPACITY   = 1024,
   parameter int INDEX_BITS = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata from bit 0 up: row[15:0], col[15:0], value[31:0], read_index[9:0], zero fill.
   input  logic [stc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_tuser: op[1:0].
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata from bit 0 up: out_row[15:0], out_col[15:0], out_value[31:0],
   // entry_total[10:0], zero fill.
   output logic [stc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // rsp_tuser: status[1:0].
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // csr_data: drop_tolerance[30:0].
   input  logic [stc_pkg::TOL_BITS-1:0]       csr_data,
   input  logic                               csr_valid,
   output logic                               csr_ready
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IB = INDEX_BITS;
   localparam int VB = VALUE_BITS;
   localparam int EW = VB + 2 * IB;
   localparam logic signed [63:0] VMAX = signed'((64'd1 << (VB - 1)) - 64'd1);
   localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

   // Every entry is packed as {value, col, row}.
   typedef enum logic [3:0] {
      S_IDLE, S_RDW, S_PASS, S_RUN, S_LDA, S_CAPA, S_LDB, S_CAPB, S_MRG,
      S_MHD, S_MHC, S_MNX, S_MNC, S_MFIN, S_MDONE
   } state_type;

   function automatic logic signed [VB-1:0] sat_val(input logic signed [63:0] x);
      if (x > VMAX) return VMAX[VB-1:0];
      if (x < VMIN) return VMIN[VB-1:0];
      return x[VB-1:0];
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return signed'(s[63:0]);
   endfunction

   function automatic logic signed [63:0] val64(input logic [EW-1:0] e);
      logic signed [VB-1:0] v;
      v = signed'(e[EW-1:2*IB]);
      return 64'(v);
   endfunction

   function automatic logic [2*IB-1:0] sort_key(input logic [EW-1:0] e);
      return {e[IB-1:0], e[2*IB-1:IB]};
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic bank_ff, bank_in;
   logic [stc_pkg::TOL_BITS-1:0] tol_ff, tol_in;
   logic [CW:0] width_ff, width_in;
   // In the merge sweep k is the head index, i the scan index and out the write index.
   logic [CW-1:0] lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, out_ff, out_in;
   logic first_ff, first_in;
   logic [EW-1:0] a_ff, a_in, b_ff, b_in, head_ff, head_in;
   logic signed [63:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic [15:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic [31:0] oval_ff, oval_in;

   logic we, wsel_other;
   logic [AW-1:0] waddr, raddr;
   logic [EW-1:0] wdata, rdata, rd0, rd1;
   logic [CW+1:0] lw;
   logic [CW+2:0] l2w;
   logic [CW-1:0] mid_c, hi_c;
   logic a_ok, b_ok, take_a;
   logic signed [VB-1:0] sv, ins_v;
   logic signed [VB:0] sx, mag;
   logic req_take;

   stc_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram0 (
      .clock(clock), .wr_en(we && ((bank_ff ^ wsel_other) == 1'b0)), .wr_addr(waddr),
      .wr_data(wdata), .rd_addr(raddr), .rd_data(rd0));
   stc_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram1 (
      .clock(clock), .wr_en(we && ((bank_ff ^ wsel_other) == 1'b1)), .wr_addr(waddr),
      .wr_data(wdata), .rd_addr(raddr), .rd_data(rd1));

   // Reads always come from the live bank; bank_ff never changes between issue and capture.
   assign rdata = bank_ff ? rd1 : rd0;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Run bounds for the current pass, clipped to the entry count.
   assign lw    = (CW + 2)'(lo_ff) + (CW + 2)'(width_ff);
   assign l2w   = (CW + 3)'(lo_ff) + (CW + 3)'({width_ff, 1'b0});
   assign mid_c = (lw < (CW + 2)'(count_ff)) ? CW'(lw) : count_ff;
   assign hi_c  = (l2w < (CW + 3)'(count_ff)) ? CW'(l2w) : count_ff;

   // The shared comparator of the sort.
   assign a_ok   = i_ff < mid_ff;
   assign b_ok   = j_ff < hi_ff;
   assign take_a = a_ok && (!b_ok || (sort_key(a_ff) <= sort_key(b_ff)));

   assign sv    = sat_val(acc_ff);
   assign sx    = (VB + 1)'(sv);
   assign mag   = (sx < 0) ? -sx : sx;
   assign ins_v = sat_val(64'(signed'(req_tdata[63:32])));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      bank_in = bank_ff;
      tol_in = (csr_valid && csr_ready) ? csr_data : tol_ff;
      width_in = width_ff;
      lo_in = lo_ff;
      mid_in = mid_ff;
      hi_in = hi_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      out_in = out_ff;
      first_in = first_ff;
      a_in = a_ff;
      b_in = b_ff;
      head_in = head_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in = status_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      oval_in = oval_ff;
      we = 1'b0;
      wsel_other = 1'b0;
      waddr = count_ff[AW-1:0];
      wdata = {ins_v, IB'(req_tdata[31:16]), IB'(req_tdata[15:0])};
      raddr = AW'(req_tdata[73:64]);
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in = stc_pkg::ST_OK;
               orow_in = '0;
               ocol_in = '0;
               oval_in = '0;
               unique case (stc_pkg::op_type'(req_tuser))
                  stc_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = stc_pkg::ST_FULL;
                     end else begin
                        we = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  stc_pkg::OP_COMPACT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        width_in = (CW + 1)'(1);
                        state_in = S_PASS;
                     end
                  end
                  stc_pkg::OP_READ: begin
                     if (32'(req_tdata[73:64]) < 32'(count_ff)) begin
                        state_in = S_RDW;
                     end else begin
                        status_in = stc_pkg::ST_BAD_READ;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  stc_pkg::OP_CLEAR: begin
                     count_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDW: begin
            orow_in = 16'(rdata[IB-1:0]);
            ocol_in = 16'(rdata[2*IB-1:IB]);
            oval_in = 32'(val64(rdata));
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_PASS: begin
            lo_in = '0;
            k_in = '0;
            out_in = '0;
            state_in = (width_ff >= (CW + 1)'(count_ff)) ? S_MHD : S_RUN;
         end
         S_RUN: begin
            if (lo_ff >= count_ff) begin
               bank_in = !bank_ff;
               width_in = {width_ff[CW-1:0], 1'b0};
               state_in = S_PASS;
            end else begin
               mid_in = mid_c;
               hi_in = hi_c;
               i_in = lo_ff;
               j_in = mid_c;
               k_in = lo_ff;
               first_in = 1'b1;
               state_in = S_LDA;
            end
         end
         S_LDA: begin
            raddr = i_ff[AW-1:0];
            state_in = S_CAPA;
         end
         S_CAPA: begin
            a_in = rdata;
            first_in = 1'b0;
            state_in = (first_ff && b_ok) ? S_LDB : S_MRG;
         end
         S_LDB: begin
            raddr = j_ff[AW-1:0];
            state_in = S_CAPB;
         end
         S_CAPB: begin
            b_in = rdata;
            state_in = S_MRG;
         end
         S_MRG: begin
            if (!a_ok && !b_ok) begin
               lo_in = hi_ff;
               state_in = S_RUN;
            end else begin
               we = 1'b1;
               wsel_other = 1'b1;
               waddr = k_ff[AW-1:0];
               wdata = take_a ? a_ff : b_ff;
               k_in = k_ff + CW'(1);
               if (take_a) begin
                  i_in = i_ff + CW'(1);
                  state_in = ((i_ff + CW'(1)) < mid_ff) ? S_LDA : S_MRG;
               end else begin
                  j_in = j_ff + CW'(1);
                  state_in = ((j_ff + CW'(1)) < hi_ff) ? S_LDB : S_MRG;
               end
            end
         end
         S_MHD: begin
            raddr = k_ff[AW-1:0];
            state_in = S_MHC;
         end
         S_MHC: begin
            head_in = rdata;
            acc_in = val64(rdata);
            i_in = k_ff + CW'(1);
            state_in = S_MNX;
         end
         S_MNX: begin
            raddr = i_ff[AW-1:0];
            state_in = (i_ff < count_ff) ? S_MNC : S_MFIN;
         end
         S_MNC: begin
            if (rdata[2*IB-1:0] == head_ff[2*IB-1:0]) begin
               acc_in = sat_add(acc_ff, val64(rdata));
               i_in = i_ff + CW'(1);
               state_in = S_MNX;
            end else begin
               state_in = S_MFIN;
            end
         end
         S_MFIN: begin
            if (64'($unsigned(mag)) > 64'(tol_ff)) begin
               we = 1'b1;
               wsel_other = 1'b1;
               waddr = out_ff[AW-1:0];
               wdata = {sv, head_ff[2*IB-1:0]};
               out_in = out_ff + CW'(1);
            end
            k_in = i_ff;
            state_in = (i_ff < count_ff) ? S_MHD : S_MDONE;
         end
         S_MDONE: begin
            bank_in = !bank_ff;
            count_in = out_ff;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         bank_ff <= 1'b0;
         tol_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bank_ff <= bank_in;
         tol_ff <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff <= width_in;
      lo_ff <= lo_in;
      mid_ff <= mid_in;
      hi_ff <= hi_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      out_ff <= out_in;
      first_ff <= first_in;
      a_ff <= a_in;
      b_ff <= b_in;
      head_ff <= head_in;
      acc_ff <= acc_in;
      status_ff <= status_in;
      orow_ff <= orow_in;
      ocol_ff <= ocol_in;
      oval_ff <= oval_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'd0, 11'(count_ff), oval_ff, ocol_ff, orow_ff};

   `STC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `STC_ASSERT_NOW(a_merge_index, clock, reset, state_ff == S_MRG, k_ff == CW'(i_ff + j_ff - mid_ff), "sort write index out of step")
   `STC_ASSERT_NOW(a_compact_shrinks, clock, reset, state_ff == S_MDONE, out_ff <= count_ff, "compaction grew the store")
   `STC_ASSERT_NEXT(a_quick_ops, clock, reset, req_take && (req_tuser == stc_pkg::OP_INSERT || req_tuser == stc_pkg::OP_CLEAR), rsp_valid_ff, "insert or clear result missing")

endmodule

/* bench/stc_checker.sv */
`timescale 1ns / 1ps
module stc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [stc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [stc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic [1:0]                        rsp_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [stc_pkg::TOL_BITS-1:0]      csr_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   output int                                pending_rsp,
   output int                                error_count
);

   localparam int DEPTH = 1024;

   typedef struct {
      stc_pkg::status_type status;
      logic [15:0]         row;
      logic [15:0]         col;
      logic [31:0]         value;
      logic [10:0]         total;
   } rsp_beat_type;

   logic [15:0]  mdl_row [DEPTH];
   logic [15:0]  mdl_col [DEPTH];
   longint       mdl_val [DEPTH];
   int           mdl_count;
   longint       mdl_tol;
   rsp_beat_type rsp_expected[$];

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Stable sort by (row, col), fold equal positions with a saturating wide sum, keep magnitudes above tolerance.
   task automatic compact_store();
      logic [31:0] key;
      logic [15:0] tr, tc;
      longint      tv, acc, s;
      int          j, m, out;
      for (int i = 1; i < mdl_count; i++) begin
         tr = mdl_row[i];
         tc = mdl_col[i];
         tv = mdl_val[i];
         key = {tr, tc};
         j = i - 1;
         while (j >= 0 && {mdl_row[j], mdl_col[j]} > key) begin
            mdl_row[j + 1] = mdl_row[j];
            mdl_col[j + 1] = mdl_col[j];
            mdl_val[j + 1] = mdl_val[j];
            j--;
         end
         mdl_row[j + 1] = tr;
         mdl_col[j + 1] = tc;
         mdl_val[j + 1] = tv;
      end
      out = 0;
      m = 0;
      while (m < mdl_count) begin
         tr = mdl_row[m];
         tc = mdl_col[m];
         acc = mdl_val[m];
         m++;
         while (m < mdl_count && mdl_row[m] == tr && mdl_col[m] == tc) begin
            s = acc + mdl_val[m];
            if (acc > 0 && mdl_val[m] > 0 && s < 0) s = 64'h7FFF_FFFF_FFFF_FFFF;
            if (acc < 0 && mdl_val[m] < 0 && s >= 0) s = 64'h8000_0000_0000_0000;
            acc = s;
            m++;
         end
         acc = clamp32(acc);
         if ((acc < 0 ? -acc : acc) > mdl_tol) begin
            mdl_row[out] = tr;
            mdl_col[out] = tc;
            mdl_val[out] = acc;
            out++;
         end
      end
      mdl_count = out;
   endtask

   task automatic predict_op(stc_pkg::op_type op, logic [15:0] row, logic [15:0] col,
                             logic [31:0] value, logic [9:0] ridx);
      rsp_beat_type e;
      e.status = stc_pkg::ST_OK;
      e.row = '0;
      e.col = '0;
      e.value = '0;
      case (op)
         stc_pkg::OP_INSERT: begin
            if (mdl_count >= DEPTH) begin
               e.status = stc_pkg::ST_FULL;
            end else begin
               mdl_row[mdl_count] = row;
               mdl_col[mdl_count] = col;
               mdl_val[mdl_count] = longint'($signed(value));
               mdl_count++;
            end
         end
         stc_pkg::OP_COMPACT: compact_store();
         stc_pkg::OP_READ: begin
            if (ridx < mdl_count) begin
               e.row = mdl_row[ridx];
               e.col = mdl_col[ridx];
               e.value = mdl_val[ridx][31:0];
            end else begin
               e.status = stc_pkg::ST_BAD_READ;
            end
         end
         default: mdl_count = 0;
      endcase
      e.total = mdl_count[10:0];
      rsp_expected.push_back(e);
   endtask

   function automatic void field_check(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
         $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, exp, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_beat_type e;
      if (reset) begin
         mdl_count = 0;
         mdl_tol = 0;
         error_count = 0;
         rsp_expected.delete();
      end else begin
         if (csr_valid && csr_ready) mdl_tol = longint'(csr_data);
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, rsp_tdata);
               error_count++;
            end else begin
               e = rsp_expected.pop_front();
               field_check("status", 32'(e.status), 32'(rsp_tuser));
               field_check("out_row", 32'(e.row), 32'(rsp_tdata[15:0]));
               field_check("out_col", 32'(e.col), 32'(rsp_tdata[31:16]));
               field_check("out_value", e.value, rsp_tdata[63:32]);
               field_check("entry_total", 32'(e.total), 32'(rsp_tdata[74:64]));
               field_check("zero fill", 32'd0, 32'(rsp_tdata[79:75]));
            end
         end
         if (req_tvalid && req_tready)
            predict_op(stc_pkg::op_type'(req_tuser), req_tdata[15:0], req_tdata[31:16],
                       req_tdata[63:32], req_tdata[73:64]);
      end
      pending_rsp = rsp_expected.size();
   end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;

   // The watchdog only counts cycles without any accepted beat, so a full
   // compact of 1024 entries must fit well inside it.
   localparam int STALL_LIMIT = 300000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic [stc_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0]                        req_tuser = '0;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [stc_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]                        rsp_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [stc_pkg::TOL_BITS-1:0]      csr_data = '0;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   int                                pending_rsp;
   int                                error_count;
   int                                idle_cycles = 0;
   int                                rsp_hold = 0;

   always #5 clock = ~clock;

   sparse_triple_compactor dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_data(csr_data), .csr_valid(csr_valid), .csr_ready(csr_ready)
   );

   stc_checker chk (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_data(csr_data), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .pending_rsp(pending_rsp), .error_count(error_count)
   );

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The response side stalls on its own schedule, changing at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
         if ($urandom_range(0, 99) < 25) rsp_hold = pick_gap();
      end
   end

   // Any accepted beat on any channel shows the block is still making progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // One request beat: present it, hold it until accepted, then maybe leave a gap.
   task automatic send_op(stc_pkg::op_type op, logic [15:0] row = '0, logic [15:0] col = '0,
                          logic [31:0] value = '0, logic [9:0] ridx = '0);
      int gap;
      req_tuser = op;
      req_tdata = {6'd0, ridx, value, col, row};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Waits for the block to drain completely before touching configuration.
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_rsp != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [30:0] tol);
      drain();
      csr_data = tol;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [15:0] pick_index();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 32'h30000) - 32'h18000;
      if (r < 8) return $urandom;
      if (r == 8) return 32'h7FFF_FFFF;
      return 32'h8000_0000;
   endfunction

   // Random traffic: mostly inserts and reads, with occasional compacts and clears.
   task automatic random_ops(int n);
      int r;
      logic [9:0] ridx;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         ridx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 20));
         if (r < 50) send_op(stc_pkg::OP_INSERT, pick_index(), pick_index(), pick_value());
         else if (r < 88) send_op(stc_pkg::OP_READ, '0, '0, '0, ridx);
         else if (r < 97) send_op(stc_pkg::OP_COMPACT);
         else send_op(stc_pkg::OP_CLEAR);
         if ($urandom_range(0, 199) == 0) drain();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_tolerance(31'd0);

      // Directed: field extremes, saturation of a sum, cancellation, bad reads.
      send_op(stc_pkg::OP_INSERT, 16'h0000, 16'h0000, 32'h8000_0000);
      send_op(stc_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd0);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd1);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd1023);
      send_op(stc_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
      send_op(stc_pkg::OP_INSERT, 16'h0005, 16'h0003, 32'h0001_0000);
      send_op(stc_pkg::OP_INSERT, 16'h0000, 16'h0000, 32'h8000_0000);
      send_op(stc_pkg::OP_INSERT, 16'h0005, 16'h0003, 32'hFFFF_0000);
      send_op(stc_pkg::OP_INSERT, 16'h0005, 16'h0002, 32'h0000_0001);
      send_op(stc_pkg::OP_COMPACT);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd0);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd1);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd2);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd3);
      send_op(stc_pkg::OP_CLEAR);
      send_op(stc_pkg::OP_COMPACT);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd0);

      // Fill the store to capacity, push past it, then compact the whole thing.
      for (int i = 0; i < 1027; i++) begin
         send_op(stc_pkg::OP_INSERT, pick_index(), pick_index(), pick_value());
      end
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd1023);
      send_op(stc_pkg::OP_COMPACT);
      send_op(stc_pkg::OP_READ, '0, '0, '0, 10'd0);
      send_op(stc_pkg::OP_CLEAR);

      random_ops(90);
      write_tolerance(31'h7FFF_FFFF);
      random_ops(90);
      write_tolerance(31'h0001_0000);
      random_ops(90);
      write_tolerance(31'($urandom));
      random_ops(90);

      drain();
      repeat (50) @(negedge clock);
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

/* sparse_triple_compactor.f */
+incdir+src
src/stc_pkg.sv
src/stc_ram.sv
src/sparse_triple_compactor.sv
bench/stc_checker.sv
bench/testbench.sv
